// ===== rtl/assert_macros.svh =====
// Assertion helpers for the deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define SFA_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define SFA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define SFA_ASSERT(label, clk, rst_n, prop)
`define SFA_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/sfa_pkg.sv =====
// ---------------------------------------------------------------------------
// sfa_pkg
// Shared constants for the start/length/end frame assembler.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package sfa_pkg;
    localparam int SFA_WINDOW_BYTES = 4096;

    localparam logic [7:0] SFA_START_RST = 8'hAA;
    localparam logic [7:0] SFA_END_RST   = 8'hBB;

    // frame overhead: start, type, two length bytes, four check bytes, end
    localparam int SFA_OVERHEAD = 9;
    localparam int SFA_TOT_W    = 17;

    localparam logic [1:0] OP_PUSH    = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;
    localparam logic [1:0] OP_NOP     = 2'd3;

    localparam logic [1:0] STAT_WAIT    = 2'd0;
    localparam logic [1:0] STAT_READY   = 2'd1;
    localparam logic [1:0] STAT_FULL    = 2'd2;
    localparam logic [1:0] STAT_NOFRAME = 2'd3;

    localparam logic CFG_START = 1'b0;
    localparam logic CFG_END   = 1'b1;

    typedef logic [7:0] t_byte;
endpackage
`default_nettype wire

// ===== rtl/sof_len_eof_frame_assembler_unit.sv =====
// ---------------------------------------------------------------------------
// sof_len_eof_frame_assembler_unit
// Start/length/end byte-stream deframer over a ring window in block RAM.
// ---------------------------------------------------------------------------
// Channel | Dir | Handshake          | Payload
// in      | in  | i_in_valid/o_in_stall | i_operation, i_rx_byte, i_read_index
// out     | out | o_out_valid/i_out_stall | o_status, o_read_data, o_frame_type,
//         |     |                    | o_payload_length, o_frame_length
// cfg     | in  | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// One transaction at a time through a sequencer around the window RAM.
// Push with frame held, full push, op 3, bad read/release, read past frame: straight
// to the result. Read within the frame: RAM read first. Push or release that scans:
// header scan first; it drops one byte per failed start, length or end check.
// Synchronous active-low reset empties the window; RAM contents are not cleared.
// A stalled result holds in the output register; the next transaction is
// taken meanwhile and waits only at the result stage.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module sof_len_eof_frame_assembler_unit #(
    parameter int WINDOW_BYTES = sfa_pkg::SFA_WINDOW_BYTES
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [1:0]  i_operation,
    input  wire  [7:0]  i_rx_byte,
    input  wire  [11:0] i_read_index,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [1:0]  o_status,
    output logic [7:0]  o_read_data,
    output logic [7:0]  o_frame_type,
    output logic [11:0] o_payload_length,
    output logic [12:0] o_frame_length,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire         i_cfg_index,
    input  wire  [7:0]  i_cfg_data
);
    import sfa_pkg::*;

    localparam int AW = $clog2(WINDOW_BYTES);
    localparam int CW = $clog2(WINDOW_BYTES + 1);
    localparam int TW = SFA_TOT_W;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_S0   = 4'd1;
    localparam logic [3:0] ST_C0   = 4'd2;
    localparam logic [3:0] ST_T    = 4'd3;
    localparam logic [3:0] ST_L0   = 4'd4;
    localparam logic [3:0] ST_L1   = 4'd5;
    localparam logic [3:0] ST_LEN  = 4'd6;
    localparam logic [3:0] ST_E    = 4'd7;
    localparam logic [3:0] ST_RD   = 4'd8;
    localparam logic [3:0] ST_PUT  = 4'd9;

    function automatic logic [AW-1:0] f_wrap(input logic [AW:0] s);
        logic [AW:0] lim;
        lim = (AW+1)'(WINDOW_BYTES);
        if (s >= lim) begin
            f_wrap = AW'(s - lim);
        end else begin
            f_wrap = AW'(s);
        end
    endfunction

    logic [3:0]    r_state, n_state;
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic          r_held, n_held;
    logic [CW-1:0] r_htot, n_htot;
    t_byte         r_type, n_type;
    t_byte         r_lo, n_lo;
    logic [15:0]   r_plen, n_plen;
    logic          r_force, n_force;
    logic [1:0]    r_pstat, n_pstat;
    t_byte         r_pdata, n_pdata;
    t_byte         r_start, r_end;

    logic          r_ov, n_ov;
    logic [1:0]    r_o_status;
    t_byte         r_o_data, r_o_type;
    logic [11:0]   r_o_plen;
    logic [12:0]   r_o_flen;

    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    t_byte         rd_data;
    logic          in_acc, out_free, do_put;
    logic [TW-1:0] tot;

    sfa_ram #(.DEPTH(WINDOW_BYTES), .AW(AW)) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(i_rx_byte),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_ov || !i_out_stall;
    assign do_put      = (r_state == ST_PUT) && out_free;
    assign tot         = TW'(r_plen) + TW'(SFA_OVERHEAD);

    always_comb begin
        n_state = r_state;
        n_head  = r_head;
        n_count = r_count;
        n_held  = r_held;
        n_htot  = r_htot;
        n_type  = r_type;
        n_lo    = r_lo;
        n_plen  = r_plen;
        n_force = r_force;
        n_pstat = r_pstat;
        n_pdata = r_pdata;
        wr_en   = 1'b0;
        wr_addr = f_wrap({1'b0, r_head} + (AW+1)'(r_count));
        rd_en   = 1'b0;
        rd_addr = r_head;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_force = 1'b0;
                    n_pdata = '0;
                    n_state = ST_PUT;
                    priority case (i_operation)
                        OP_PUSH: begin
                            if (r_count >= CW'(WINDOW_BYTES)) begin
                                n_force = 1'b1;
                                n_pstat = STAT_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                n_count = r_count + 1'b1;
                                if (!r_held) begin
                                    n_state = ST_S0;
                                end
                            end
                        end
                        OP_READ: begin
                            if (!r_held) begin
                                n_force = 1'b1;
                                n_pstat = STAT_NOFRAME;
                            end else if (TW'(i_read_index) < TW'(r_htot)) begin
                                rd_en   = 1'b1;
                                rd_addr = f_wrap({1'b0, r_head}
                                                 + (AW+1)'(i_read_index));
                                n_state = ST_RD;
                            end
                        end
                        OP_RELEASE: begin
                            if (!r_held) begin
                                n_force = 1'b1;
                                n_pstat = STAT_NOFRAME;
                            end else begin
                                if (r_htot >= r_count) begin
                                    n_head  = '0;
                                    n_count = '0;
                                end else begin
                                    n_head  = f_wrap({1'b0, r_head} + (AW+1)'(r_htot));
                                    n_count = r_count - r_htot;
                                end
                                n_held  = 1'b0;
                                n_htot  = '0;
                                n_state = ST_S0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_S0: begin
                if (r_count == '0) begin
                    n_state = ST_PUT;
                end else begin
                    rd_en   = 1'b1;
                    n_state = ST_C0;
                end
            end
            ST_C0: begin
                if (rd_data != r_start) begin
                    // drop one byte and look again
                    if (r_count <= CW'(1)) begin
                        n_head  = '0;
                        n_count = '0;
                    end else begin
                        n_head  = f_wrap({1'b0, r_head} + 1'b1);
                        n_count = r_count - 1'b1;
                    end
                    n_state = ST_S0;
                end else if (r_count < CW'(4)) begin
                    n_state = ST_PUT;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = f_wrap({1'b0, r_head} + (AW+1)'(1));
                    n_state = ST_T;
                end
            end
            ST_T: begin
                n_type  = rd_data;
                rd_en   = 1'b1;
                rd_addr = f_wrap({1'b0, r_head} + (AW+1)'(2));
                n_state = ST_L0;
            end
            ST_L0: begin
                n_lo    = rd_data;
                rd_en   = 1'b1;
                rd_addr = f_wrap({1'b0, r_head} + (AW+1)'(3));
                n_state = ST_L1;
            end
            ST_L1: begin
                n_plen  = {rd_data, r_lo};
                n_state = ST_LEN;
            end
            ST_LEN: begin
                if (tot > TW'(WINDOW_BYTES)) begin
                    n_head  = f_wrap({1'b0, r_head} + 1'b1);
                    n_count = r_count - 1'b1;
                    n_state = ST_S0;
                end else if (TW'(r_count) < tot) begin
                    n_state = ST_PUT;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = f_wrap({1'b0, r_head} + (AW+1)'(tot - 1'b1));
                    n_state = ST_E;
                end
            end
            ST_E: begin
                if (rd_data != r_end) begin
                    n_head  = f_wrap({1'b0, r_head} + 1'b1);
                    n_count = r_count - 1'b1;
                    n_state = ST_S0;
                end else begin
                    n_held  = 1'b1;
                    n_htot  = CW'(tot);
                    n_state = ST_PUT;
                end
            end
            ST_RD: begin
                n_pdata = rd_data;
                n_state = ST_PUT;
            end
            ST_PUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_ov = r_ov;
        if (do_put) begin
            n_ov = 1'b1;
        end else if (r_ov && !i_out_stall) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_held  <= 1'b0;
            r_htot  <= '0;
            r_ov    <= 1'b0;
            r_start <= SFA_START_RST;
            r_end   <= SFA_END_RST;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_held  <= n_held;
            r_htot  <= n_htot;
            r_ov    <= n_ov;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_START: r_start <= i_cfg_data;
                    CFG_END:   r_end   <= i_cfg_data;
                    default:   r_start <= r_start;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_type  <= n_type;
        r_lo    <= n_lo;
        r_plen  <= n_plen;
        r_force <= n_force;
        r_pstat <= n_pstat;
        r_pdata <= n_pdata;
        if (do_put) begin
            r_o_data <= r_pdata;
            if (r_force) begin
                r_o_status <= r_pstat;
            end else begin
                r_o_status <= r_held ? STAT_READY : STAT_WAIT;
            end
            if (r_held) begin
                r_o_type <= r_type;
                r_o_plen <= r_plen[11:0];
                r_o_flen <= 13'(r_htot);
            end else begin
                r_o_type <= '0;
                r_o_plen <= '0;
                r_o_flen <= '0;
            end
        end
    end

    assign o_out_valid      = r_ov;
    assign o_status         = r_o_status;
    assign o_read_data      = r_o_data;
    assign o_frame_type     = r_o_type;
    assign o_payload_length = r_o_plen;
    assign o_frame_length   = r_o_flen;

    `SFA_ASSERT(a_count_max, i_clk, i_rst_n, r_count <= CW'(WINDOW_BYTES))
    `SFA_ASSERT(a_head_range, i_clk, i_rst_n, {1'b0, r_head} < (AW+1)'(WINDOW_BYTES))
    `SFA_ASSERT_IMPLY(a_held_fits, i_clk, i_rst_n, r_held,
        (r_htot <= r_count) && (TW'(r_htot) >= TW'(SFA_OVERHEAD)))
    `SFA_ASSERT_IMPLY(a_put_loads, i_clk, i_rst_n, do_put, ##1 r_ov)
endmodule
`default_nettype wire

// ===== rtl/sfa_ram.sv =====
// ---------------------------------------------------------------------------
// sfa_ram
// Window byte store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module sfa_ram #(
    parameter int DEPTH = sfa_pkg::SFA_WINDOW_BYTES,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire                 i_clk,
    input  wire                 i_wr_en,
    input  wire [AW-1:0]        i_wr_addr,
    input  wire sfa_pkg::t_byte i_wr_data,
    input  wire                 i_rd_en,
    input  wire [AW-1:0]        i_rd_addr,
    output sfa_pkg::t_byte      o_rd_data
);
    import sfa_pkg::*;

    t_byte r_mem [DEPTH];
    t_byte r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule
`default_nettype wire
